// ===== rtl/core/teq_pkg.sv =====
package teq_pkg;

    // Field widths of the stream payloads
    localparam int ACT_W    = 2;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 11;
    localparam int STAT_W   = 2;
    localparam int TOT_W    = 11;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [STAT_W-1:0] status_t;

    // Action codes
    localparam action_t ACT_BACK  = 2'd0;
    localparam action_t ACT_FRONT = 2'd1;
    localparam action_t ACT_MID   = 2'd2;
    localparam action_t ACT_READ  = 2'd3;

    // Status codes
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_RANGE = 2'd2;

endpackage

// ===== rtl/core/teq_ram.sv =====
module teq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/three_ended_queue.sv =====
// The result is loaded into the output register in the FINISH state that follows acceptance,
// and is held back there only while the previous result still waits for the receiver.
// A new item is taken only once the current one has finished; a rebalance reads one half's memory
// (registered read) on acceptance and writes the other half's memory when the item finishes.
// Reset: asynchronous, active low; clears heads, counts, state and output valid. The two
// element memories are not cleared and need no clearing pass.
module three_ended_queue #(
    parameter int HALF_DEPTH = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // value [31:0], index [42:32], zero [47:43]
    input  logic [teq_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // action [1:0]
    input  teq_pkg::action_t              s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data [31:0], total_count [42:32], zero [47:43]
    output logic [teq_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output teq_pkg::status_t              m_axis_tuser
);

    import teq_pkg::*;

    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW = $clog2(2 * HALF_DEPTH);
    localparam int SW = CW + 1;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAPACITY = CW'(2 * HALF_DEPTH - 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(pos) + SW'(off);
        if (sum >= SW'(HALF_DEPTH))
        begin
            sum = sum - SW'(HALF_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] pos);
        logic [AW-1:0] res;
        if (pos == '0)
        begin
            res = AW'(HALF_DEPTH - 1);
        end
        else
        begin
            res = pos - AW'(1);
        end
        return res;
    endfunction

    // Control and state registers
    logic          state_reg, state_next;
    logic [AW-1:0] fhead_reg, bhead_reg;
    logic [CW-1:0] fcount_reg, bcount_reg;
    logic          out_valid_reg;

    // Held per-item work between acceptance and finish
    logic                  move_reg;
    logic                  move_f2b_reg;
    logic [AW-1:0]         move_addr_reg;
    logic                  fwd_reg;
    logic [DATA_WIDTH-1:0] fwd_val_reg;
    logic                  rd_ok_reg;
    logic                  rd_front_reg;
    status_t               stat_reg;
    logic [TOT_W-1:0]      tot_reg;

    // Output register
    status_t          out_stat_reg;
    logic [VAL_W-1:0] out_data_reg;
    logic [TOT_W-1:0] out_tot_reg;

    // Input unpacking
    action_t               action;
    logic [VAL_W-1:0]      value;
    logic [IDX_W-1:0]      index;
    logic [63:0]           value_x;
    logic [DATA_WIDTH-1:0] value_d;

    assign action  = s_axis_tuser;
    assign value   = s_axis_tdata[VAL_W-1:0];
    assign index   = s_axis_tdata[VAL_W+IDX_W-1:VAL_W];
    assign value_x = 64'(value);
    assign value_d = DATA_WIDTH'(value_x);

    logic accept, finish_go;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish_go     = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    // Plan of the item: push, rebalance move and read addresses
    logic [CW-1:0] total;
    logic          is_read, full, do_push, out_range, in_front;
    logic [XW-1:0] idx_x, total_x, fcount_x, boff_x;
    logic [CW-1:0] idx_c, boff;
    logic [AW-1:0] fh1, bh1, fh2, bh2;
    logic [CW-1:0] f1, b1, f2, b2;
    logic [AW-1:0] front_push_addr, back_push_addr;
    logic [AW-1:0] front_raddr, back_raddr, move_addr;
    logic          f2b, b2f, fwd;
    logic [CW-1:0] total_after;
    logic [XW-1:0] total_after_x;
    status_t       stat_d;

    assign total     = fcount_reg + bcount_reg;
    assign is_read   = (action == ACT_READ);
    assign full      = (total >= CAPACITY);
    assign do_push   = !is_read && !full;
    assign idx_x     = XW'(index);
    assign total_x   = XW'(total);
    assign fcount_x  = XW'(fcount_reg);
    assign boff_x    = idx_x - fcount_x;
    assign idx_c     = idx_x[CW-1:0];
    assign boff      = boff_x[CW-1:0];
    assign out_range = (idx_x >= total_x);
    assign in_front  = (idx_x < fcount_x);

    always_comb
    begin
        fh1 = fhead_reg;
        bh1 = bhead_reg;
        f1  = fcount_reg;
        b1  = bcount_reg;
        back_push_addr = bhead_reg;
        unique case (action)
            ACT_BACK:
            begin
                back_push_addr = ring_add(bhead_reg, bcount_reg);
                b1 = bcount_reg + CW'(1);
            end
            ACT_FRONT:
            begin
                fh1 = ring_dec(fhead_reg);
                f1  = fcount_reg + CW'(1);
            end
            ACT_MID:
            begin
                bh1 = ring_dec(bhead_reg);
                back_push_addr = bh1;
                b1 = bcount_reg + CW'(1);
            end
            default:
            begin
                fh1 = fhead_reg;
            end
        endcase
        front_push_addr = fh1;

        // Halves stay balanced, so one move at most restores the rule
        f2b = (action == ACT_FRONT) && (fcount_reg != bcount_reg);
        b2f = ((action == ACT_BACK) || (action == ACT_MID)) && (fcount_reg == bcount_reg);

        fh2 = fh1;
        bh2 = bh1;
        f2  = f1;
        b2  = b1;
        front_raddr = ring_add(fhead_reg, idx_c);
        back_raddr  = ring_add(bhead_reg, boff);
        move_addr   = bh1;
        fwd         = 1'b0;
        if (!is_read && f2b)
        begin
            front_raddr = ring_add(fh1, fcount_reg);
            bh2       = ring_dec(bh1);
            move_addr = bh2;
            f2        = fcount_reg;
            b2        = b1 + CW'(1);
            fwd       = (front_raddr == front_push_addr);
        end
        else if (!is_read && b2f)
        begin
            back_raddr = bh1;
            bh2       = ring_add(bh1, CW'(1));
            move_addr = ring_add(fh1, f1);
            b2        = bcount_reg;
            f2        = f1 + CW'(1);
            fwd       = (back_raddr == back_push_addr);
        end

        // Result status and element count
        priority if (is_read && out_range)
        begin
            stat_d = STAT_RANGE;
        end
        else if (!is_read && full)
        begin
            stat_d = STAT_FULL;
        end
        else
        begin
            stat_d = STAT_OK;
        end
        total_after = do_push ? (f2 + b2) : total;
    end

    assign total_after_x = XW'(total_after);

    // Memory ports: push on acceptance, move at finish
    logic                  front_we, back_we;
    logic [AW-1:0]         front_waddr, back_waddr;
    logic [DATA_WIDTH-1:0] front_wdata, back_wdata;
    logic [DATA_WIDTH-1:0] front_rdata, back_rdata;
    logic [DATA_WIDTH-1:0] move_val;

    assign move_val = fwd_reg ? fwd_val_reg : (move_f2b_reg ? front_rdata : back_rdata);

    always_comb
    begin
        if (state_reg == ST_FINISH)
        begin
            front_we    = finish_go && move_reg && !move_f2b_reg;
            back_we     = finish_go && move_reg && move_f2b_reg;
            front_waddr = move_addr_reg;
            back_waddr  = move_addr_reg;
            front_wdata = move_val;
            back_wdata  = move_val;
        end
        else
        begin
            front_we    = accept && do_push && (action == ACT_FRONT);
            back_we     = accept && do_push && (action != ACT_FRONT);
            front_waddr = front_push_addr;
            back_waddr  = back_push_addr;
            front_wdata = value_d;
            back_wdata  = value_d;
        end
    end

    teq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (AW)
    ) u_front_ram (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .re    (accept),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    teq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (AW)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .re    (accept),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FINISH;
                end
            end
            default:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Control state: heads and counts advance on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fhead_reg     <= '0;
            bhead_reg     <= '0;
            fcount_reg    <= '0;
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            move_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                move_reg <= do_push && (f2b || b2f);
                if (do_push)
                begin
                    fhead_reg  <= fh2;
                    bhead_reg  <= bh2;
                    fcount_reg <= f2;
                    bcount_reg <= b2;
                end
            end
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item's work for the finish cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            move_f2b_reg  <= f2b;
            move_addr_reg <= move_addr;
            fwd_reg       <= fwd;
            fwd_val_reg   <= value_d;
            rd_ok_reg     <= is_read && !out_range;
            rd_front_reg  <= in_front;
            stat_reg      <= stat_d;
            tot_reg       <= total_after_x[TOT_W-1:0];
        end
    end

    // Load the output register
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [63:0]           rd_x;

    assign rd_sel = rd_front_reg ? front_rdata : back_rdata;
    assign rd_x   = 64'(rd_sel);

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_stat_reg <= stat_reg;
            out_data_reg <= rd_ok_reg ? rd_x[VAL_W-1:0] : '0;
            out_tot_reg  <= tot_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tdata  = {{(M_DATA_W - VAL_W - TOT_W){1'b0}}, out_tot_reg, out_data_reg};

endmodule
